// ===== hdl/ole_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types, codes and defaults for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int GROUP_SIZE      = 8;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_POP    = 3'd3,
        OP_SEARCH = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_INSERT  = 2'd1,
        CELL_REMOVE  = 2'd2,
        CELL_COMPARE = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic done;
        logic found;
    } scan_stat_t;

endpackage

`default_nettype wire

// ===== hdl/ole_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ole_cell
// One list slot: holds a word, shifts with its neighbors, compares on search.
// ----------------------------------------------------------------------------
module ole_cell #(
    parameter int INDEX       = 0,
    parameter int VALUE_WIDTH = ole_pkg::VALUE_WIDTH_DEF,
    parameter int CNT_W       = 7
) (
    input  wire                   aclk,
    input  ole_pkg::cell_op_t     op,
    input  wire [CNT_W-1:0]       pos,
    input  wire [CNT_W-1:0]       count,
    input  wire [VALUE_WIDTH-1:0] word,
    input  wire [VALUE_WIDTH-1:0] left_data,
    input  wire [VALUE_WIDTH-1:0] right_data,
    output logic [VALUE_WIDTH-1:0] data,
    output logic                  hit
);
    import ole_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [VALUE_WIDTH-1:0] data_reg;
    logic                   hit_reg;

    always_ff @(posedge aclk) begin
        case (op)
            CELL_INSERT: begin
                if (pos == MY_IDX) begin
                    data_reg <= word;
                end else if (pos < MY_IDX) begin
                    data_reg <= left_data;
                end
            end
            CELL_REMOVE: begin
                // close the gap: this slot and everything above take the upper neighbor
                if (pos <= MY_IDX) begin
                    data_reg <= right_data;
                end
            end
            CELL_COMPARE: begin
                hit_reg <= (data_reg == word) && (MY_IDX < count);
            end
            default: begin
            end
        endcase
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

`default_nettype wire

// ===== hdl/ole_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ole_scan
// Walks the registered hit vector eight cells a cycle, lowest group first.
// ----------------------------------------------------------------------------
module ole_scan #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF,
    parameter int CNT_W    = 7,
    parameter int IDX_W    = 6
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 start,
    input  wire [CNT_W-1:0]     count,
    input  wire [CAPACITY-1:0]  hits,
    output ole_pkg::scan_stat_t stat,
    output logic [IDX_W-1:0]    index
);
    import ole_pkg::*;

    localparam int NGRP  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PAD_W = NGRP * GROUP_SIZE;
    localparam int FULL_W = GRP_W + 3;

    logic               busy_reg, busy_next;
    logic [GRP_W-1:0]   grp_reg, grp_next;
    logic [GRP_W-1:0]   last_reg, last_next;

    logic [PAD_W-1:0]      hits_pad;
    logic [GROUP_SIZE-1:0] grp_bits;
    logic [2:0]            enc;
    logic [CNT_W-1:0]      cnt_m1;
    logic [CNT_W+2:0]      last_wide;
    logic [FULL_W-1:0]     full_idx;

    assign hits_pad  = PAD_W'(hits);
    assign grp_bits  = hits_pad[grp_reg * GROUP_SIZE +: GROUP_SIZE];
    assign cnt_m1    = count - CNT_W'(1);
    assign last_wide = {3'b000, cnt_m1} >> 3;

    // lowest set bit in the current group
    always_comb begin
        enc = 3'd0;
        for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
            if (grp_bits[i]) begin
                enc = 3'(i);
            end
        end
    end

    assign full_idx   = {grp_reg, enc};
    assign index      = full_idx[IDX_W-1:0];
    assign stat.found = |grp_bits;
    assign stat.done  = busy_reg && ((|grp_bits) || (grp_reg == last_reg));

    always_comb begin
        busy_next = busy_reg;
        grp_next  = grp_reg;
        last_next = last_reg;
        if (start) begin
            busy_next = 1'b1;
            grp_next  = '0;
            last_next = last_wide[GRP_W-1:0];
        end else if (stat.done) begin
            busy_next = 1'b0;
        end else if (busy_reg) begin
            grp_next = grp_reg + GRP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        grp_reg  <= grp_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

// ===== hdl/ordered_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_engine
// Fixed-capacity ordered word list held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis beat: tuser carries the opcode (append,
//   insert, remove, pop, search), tdata carries position and value. Each
//   request returns exactly one m_axis beat: tuser is the status, tdata holds
//   the found index and the entry count after the request.
//   Append, insert and remove shift the cells from the position upward in
//   the accepting cycle, pop only lowers the count, and the result sits in
//   the output register on the next cycle. Such requests run back to back
//   at one beat per cycle as long as the receiver keeps up.
//   Search compares all cells in the accepting cycle, then walks the hit
//   flags eight cells per cycle from index 0, stopping at the first hit or at
//   the last occupied group; an empty list is reported as not found without
//   a walk. No request is taken while a search walks.
//   A stalled receiver holds the result; the next request is taken once the
//   output register is empty or being drained in the same cycle.
//   Reset empties the list and drops any pending result; stored words are
//   not cleared, since no slot at or above the count is ever read.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
    parameter int CAPACITY    = ole_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = ole_pkg::VALUE_WIDTH_DEF,
    localparam int CNT_W  = $clog2(CAPACITY + 1),
    localparam int IDX_W  = $clog2(CAPACITY),
    localparam int IN_W   = ((CNT_W + VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W  = ((IDX_W + CNT_W + 7) / 8) * 8
) (
    input  wire              aclk,
    input  wire              aresetn,
    // request channel
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire [IN_W-1:0]   s_axis_tdata,   // position, value
    input  wire [2:0]        s_axis_tuser,   // opcode
    // result channel
    output logic             m_axis_tvalid,
    input  wire              m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // found_index, count
    output logic [2:0]       m_axis_tuser    // status
);
    import ole_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_valid_reg, m_valid_next;
    status_t           status_reg, status_next;
    logic [IDX_W-1:0]  fidx_reg, fidx_next;
    logic [CNT_W-1:0]  cnt_out_reg, cnt_out_next;

    logic              accept;
    op_t               req_op;
    logic [CNT_W-1:0]  req_pos;
    logic [VALUE_WIDTH-1:0] req_word;
    logic              full;
    logic              empty;

    cell_op_t          cell_op;
    logic [CNT_W-1:0]  cell_pos;
    logic              scan_start;

    logic [VALUE_WIDTH-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]    cell_hit;
    scan_stat_t             scan_stat;
    logic [IDX_W-1:0]       scan_idx;

    // unpack the request beat
    assign req_op   = op_t'(s_axis_tuser);
    assign req_pos  = s_axis_tdata[CNT_W-1:0];
    assign req_word = s_axis_tdata[CNT_W +: VALUE_WIDTH];

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    assign s_axis_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        status_next  = status_reg;
        fidx_next    = fidx_reg;
        cnt_out_next = cnt_out_reg;
        cell_op      = CELL_HOLD;
        cell_pos     = req_pos;
        scan_start   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    status_next = ST_OK;
                    fidx_next   = '0;
                    case (req_op)
                        OP_APPEND: begin
                            // append is an insert at the current count
                            if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                cell_op    = CELL_INSERT;
                                cell_pos   = count_reg;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_INSERT: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else if (req_pos > count_reg) begin
                                status_next = ST_BADPOS;
                            end else begin
                                cell_op    = CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_REMOVE: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else if (req_pos >= count_reg) begin
                                status_next = ST_BADPOS;
                            end else begin
                                cell_op    = CELL_REMOVE;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_SEARCH: begin
                            if (empty) begin
                                status_next = ST_NOTFOUND;
                            end else begin
                                cell_op    = CELL_COMPARE;
                                scan_start = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                    cnt_out_next = count_next;
                    // a search on a non-empty list reports from the scan state
                    m_valid_next = !scan_start;
                end
            end
            S_SCAN: begin
                // output register is free here: it was free when the search was taken
                if (scan_stat.done) begin
                    m_valid_next = 1'b1;
                    status_next  = scan_stat.found ? ST_OK : ST_NOTFOUND;
                    fidx_next    = scan_stat.found ? scan_idx : '0;
                    cnt_out_next = count_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        status_reg  <= status_next;
        fidx_reg    <= fidx_next;
        cnt_out_reg <= cnt_out_next;
    end

    // row of cells; the ends see zero beyond the list
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left_w;
        logic [VALUE_WIDTH-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        ole_cell #(
            .INDEX       (i),
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_W       (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .op         (cell_op),
            .pos        (cell_pos),
            .count      (count_reg),
            .word       (req_word),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .hit        (cell_hit[i])
        );
    end

    ole_scan #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .IDX_W    (IDX_W)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scan_start),
        .count   (count_reg),
        .hits    (cell_hit),
        .stat    (scan_stat),
        .index   (scan_idx)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_W'({cnt_out_reg, fidx_reg});
    assign m_axis_tuser  = status_reg;

endmodule

`default_nettype wire

// ===== sim/ordered_list_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_test
// Self-checking bench for the ordered list engine: requests stream in from a
// queue, a local list model predicts each status, found index and count, and
// every result beat is checked in order against that prediction.
// ----------------------------------------------------------------------------
module ordered_list_engine_test;
    import ole_pkg::*;

    localparam int CAP      = CAPACITY_DEF;
    localparam int WORD_W   = VALUE_WIDTH_DEF;
    localparam int REQ_W    = ((7 + WORD_W + 7) / 8) * 8;
    localparam int RSP_W    = ((6 + 7 + 7) / 8) * 8;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 12;

    // opcodes with no operation behind them
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]        opc;
        logic [6:0]        pos;
        logic [WORD_W-1:0] word;
    } request_t;

    typedef struct packed {
        status_t    status;
        logic [5:0] index;
        logic [6:0] count;
    } outcome_t;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    wire               s_tready;
    logic [REQ_W-1:0]  s_tdata = '0;   // position, value
    logic [2:0]        s_tuser = '0;   // opcode
    wire               m_tvalid;
    logic              m_tready = 1'b0;
    wire  [RSP_W-1:0]  m_tdata;        // found_index, count
    wire  [2:0]        m_tuser;        // status

    ordered_list_engine u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    request_t          pending_reqs[$];
    outcome_t          expected_outcomes[$];
    logic [WORD_W-1:0] list_words[CAP];
    int                list_len = 0;
    int                errors = 0;
    int                send_idle_pct = 31;
    int                recv_idle_pct = 46;
    bit                hold_off = 1'b0;
    request_t          next_req;

    // stimulus-side view of the count, so positions can be aimed at the list
    int                gen_len = 0;
    bit                growing = 1'b1;
    logic [WORD_W-1:0] word_pool[8];

    // Apply one request to the local list and return what the block reports.
    function automatic outcome_t apply_request(logic [2:0] opc, logic [6:0] pos,
                                               logic [WORD_W-1:0] word);
        outcome_t res;
        res.status = ST_OK;
        res.index  = '0;
        case (opc)
            OP_APPEND: begin
                if (list_len >= CAP) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_len] = word;
                    list_len++;
                end
            end
            OP_INSERT: begin
                if (list_len >= CAP) begin
                    res.status = ST_FULL;
                end else if (pos > list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
                    list_words[pos] = word;
                    list_len++;
                end
            end
            OP_REMOVE: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos >= list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            OP_POP: begin
                if (list_len == 0) res.status = ST_EMPTY;
                else list_len--;
            end
            OP_SEARCH: begin
                res.status = ST_NOTFOUND;
                for (int i = 0; i < list_len; i++) begin
                    if (list_words[i] == word) begin
                        res.status = ST_OK;
                        res.index  = i[5:0];
                        break;
                    end
                end
            end
            default: ;
        endcase
        res.count = list_len[6:0];
        return res;
    endfunction

    // Queue a request and track the count it leaves behind.
    function automatic void queue_request(logic [2:0] opc, int pos,
                                          logic [WORD_W-1:0] word);
        request_t r;
        r.opc  = opc;
        r.pos  = pos[6:0];
        r.word = word;
        pending_reqs.push_back(r);
        case (opc)
            OP_APPEND: if (gen_len < CAP) gen_len++;
            OP_INSERT: if (gen_len < CAP && pos <= gen_len) gen_len++;
            OP_REMOVE: if (gen_len > 0 && pos < gen_len) gen_len--;
            OP_POP:    if (gen_len > 0) gen_len--;
            default: ;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_word(int pool_pct);
        if ($urandom_range(99) < pool_pct) return word_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // Queue one random request; returns 0 when it was a spare opcode.
    // Grow the list toward full, linger there, then shrink it to empty.
    function automatic bit queue_random();
        int r;
        int live_pos;
        r = $urandom_range(99);
        live_pos = (gen_len == 0) ? 0 : $urandom_range(gen_len - 1, 0);
        if (growing && gen_len == CAP && $urandom_range(3) == 0) growing = 1'b0;
        if (!growing && gen_len == 0 && $urandom_range(3) == 0) growing = 1'b1;
        if (r >= 96) begin
            if ($urandom_range(1)) begin
                queue_request(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)),
                              $urandom_range(127), $urandom);
                return 1'b0;
            end
            queue_request($urandom_range(1) ? OP_INSERT : OP_REMOVE,
                          $urandom_range(CAP), pick_word(50));
        end else if (r >= 84) begin
            queue_request(OP_SEARCH, $urandom_range(CAP), pick_word(70));
        end else if (growing) begin
            if (r < 40)      queue_request(OP_APPEND, $urandom_range(CAP), pick_word(60));
            else if (r < 70) queue_request(OP_INSERT, $urandom_range(gen_len, 0),
                                           pick_word(60));
            else if (r < 78) queue_request(OP_REMOVE, live_pos, $urandom);
            else             queue_request(OP_POP, $urandom_range(CAP), $urandom);
        end else begin
            if (r < 10)      queue_request(OP_APPEND, $urandom_range(CAP), pick_word(60));
            else if (r < 20) queue_request(OP_INSERT, $urandom_range(gen_len, 0),
                                           pick_word(60));
            else if (r < 60) queue_request(OP_REMOVE, live_pos, $urandom);
            else             queue_request(OP_POP, $urandom_range(CAP), $urandom);
        end
        return 1'b1;
    endfunction

    // Driver: predict each accepted beat, then offer the next request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_outcomes.push_back(apply_request(s_tuser, s_tdata[6:0],
                                                          s_tdata[7 +: WORD_W]));
            end
            if (!s_tvalid || s_tready) begin
                if (hold_off || pending_reqs.size() == 0 ||
                    $urandom_range(99) < send_idle_pct) begin
                    s_tvalid <= 1'b0;
                end else begin
                    next_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_req.opc;
                    s_tdata  <= {{(REQ_W - 7 - WORD_W){1'b0}}, next_req.word, next_req.pos};
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: result beat with nothing expected: status %0d data %h",
                             $realtime, m_tuser, m_tdata);
                    errors++;
                end else begin
                    outcome_t want;
                    want = expected_outcomes.pop_front();
                    if (m_tuser !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, want.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[5:0] !== want.index) begin
                        $display("%0t: found_index expected %0d actual %0d",
                                 $realtime, want.index, m_tdata[5:0]);
                        errors++;
                    end
                    if (m_tdata[12:6] !== want.count) begin
                        $display("%0t: count expected %0d actual %0d",
                                 $realtime, want.count, m_tdata[12:6]);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    int cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0) @(negedge aclk);
    endtask

    task automatic wait_quiet();
        while (pending_reqs.size() != 0 || s_tvalid || expected_outcomes.size() != 0)
            @(negedge aclk);
    endtask

    task automatic queue_phase();
        int queued;
        queued = 0;
        while (queued < ITEMS_PER_PHASE) queued += queue_random();
    endtask

    initial begin
        foreach (word_pool[i]) word_pool[i] = $urandom;
        word_pool[0] = '0;
        word_pool[1] = '1;

        // Empty-list errors, edge positions, duplicates and spare opcodes.
        queue_request(OP_POP,    0, '0);
        queue_request(OP_REMOVE, 0, '0);
        queue_request(OP_SEARCH, 0, '0);
        queue_request(OP_INSERT, 1, 32'h0BAD_0001);
        queue_request(OP_INSERT, 0, '1);
        queue_request(OP_APPEND, 0, '0);
        queue_request(OP_APPEND, 127, 32'h1234_5678);
        queue_request(OP_INSERT, 3, 32'hA5A5_A5A5);   // at the count acts as append
        queue_request(OP_INSERT, 1, '0);              // duplicate word
        queue_request(OP_SEARCH, 0, '0);              // lowest of two matches
        queue_request(OP_SEARCH, 0, '1);
        queue_request(OP_SEARCH, 0, 32'hA5A5_A5A5);   // last entry
        queue_request(OP_SEARCH, 0, 32'h5A5A_5A5A);   // no match
        queue_request(OP_REMOVE, 5, '0);              // at the count
        queue_request(OP_REMOVE, CAP, '0);
        queue_request(OP_INSERT, CAP, '1);
        queue_request(OP_REMOVE, 0, '0);
        queue_request(OP_SPARE_FIRST, 2, '1);
        queue_request(3'd6, 127, 32'hDEAD_BEEF);
        queue_request(OP_SPARE_LAST, 0, '0);
        queue_request(OP_REMOVE, 3, '0);              // last entry
        queue_request(OP_POP, 0, '0);
        queue_request(OP_SEARCH, 0, 32'h1234_5678);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        queue_phase();
        wait_drained();

        // Hold the sender until every outstanding result is back.
        hold_off = 1'b1;
        wait_quiet();
        repeat (5) @(negedge aclk);
        hold_off = 1'b0;

        send_idle_pct = 46;
        recv_idle_pct = 31;
        queue_phase();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_phase();
        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
